/* rtl/plis_pkg.sv */
`timescale 1ns / 1ps

package plis_pkg;

  localparam int COORD_FRAC_BITS = 8;

  localparam int COORD_W  = 16;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int D2_W     = SQ_W;
  localparam int AXP_W    = COORD_W + DIFF_W;
  localparam int DOT_W    = AXP_W + 2;
  localparam int SQ_OUT_W = D2_W / 2;
  localparam int SQ_REM_W = SQ_OUT_W + 1;

  localparam int DIV_QW = 21;
  localparam int DIV_NW = 36 + 2 * COORD_FRAC_BITS;
  localparam int DIV_DW = D2_W + 17;

  localparam int PT_PROD_W = 16 + D2_W;
  localparam int PT_DLY    = SQ_OUT_W + DIV_QW + 1;

  localparam int COS_W      = 16;
  localparam int COS_MAG_W  = COS_W + 1;
  localparam int CLAMP_SHIFT = 16;
  localparam int SP_PROD_W  = 32;
  localparam int TOT_W      = 26;
  localparam int OUT_W      = 24;

  localparam logic [DIV_DW-1:0] PT_DEN_ONE = DIV_DW'(1) << (16 + 2 * COORD_FRAC_BITS);
  localparam logic [D2_W:0] SP_DEN_ONE = (D2_W + 1)'(1) << (2 * COORD_FRAC_BITS);

  localparam logic [DIV_QW-1:0] COS_LIMIT_Q = DIV_QW'(32768);
  localparam logic [COS_MAG_W-1:0] COS_MAG_MAX = COS_MAG_W'(32768);
  localparam logic [COS_MAG_W-1:0] COS_POS_MAX = COS_MAG_W'(32767);

  localparam logic signed [TOT_W-1:0] OUT_MAX = TOT_W'(8388607);
  localparam logic signed [TOT_W-1:0] OUT_MIN = -TOT_W'(8388608);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam logic signed [15:0] CONE_COS_RESET = 16'sd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIR_LEVEL  = 3'd0,
    REG_PT_POS     = 3'd1,
    REG_PT_PEAK    = 3'd2,
    REG_PT_FALLOFF = 3'd3,
    REG_SP_POS     = 3'd4,
    REG_SP_AXIS    = 3'd5,
    REG_SP_CONE    = 3'd6,
    REG_SP_PEAK    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] total_light;
    logic                    saturated;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pt_pos;
    logic [CFG_DATA_W-1:0] sp_pos;
    logic [CFG_DATA_W-1:0] sp_axis;
  } light_geom_t;

  function automatic logic signed [COORD_W-1:0] half(input logic [CFG_DATA_W-1:0] v,
                                                     input int k);
    return $signed(v[COORD_W*k +: COORD_W]);
  endfunction

endpackage

/* rtl/plis_front.sv */
`timescale 1ns / 1ps

module plis_front
  import plis_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  in_beat_t                in_pt,
  input  light_geom_t             geom,
  output logic                    out_vld,
  output logic [D2_W-1:0]         out_d2_pt,
  output logic [D2_W-1:0]         out_d2_sp,
  output logic signed [DOT_W-1:0] out_dot
);

  logic signed [COORD_W-1:0] p_c [3];
  logic [2:0]                vld_r;
  logic signed [DIFF_W-1:0]  pdiff_r [3];
  logic signed [DIFF_W-1:0]  sdiff_r [3];
  logic signed [SQ_W-1:0]    psq_r [3];
  logic signed [SQ_W-1:0]    ssq_r [3];
  logic signed [AXP_W-1:0]   axp_r [3];
  logic [D2_W-1:0]           d2_pt_r;
  logic [D2_W-1:0]           d2_sp_r;
  logic signed [DOT_W-1:0]   dot_r;

  assign p_c[0] = in_pt.point_x;
  assign p_c[1] = in_pt.point_y;
  assign p_c[2] = in_pt.point_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pdiff_r[k] <= DIFF_W'(p_c[k]) - DIFF_W'(half(geom.pt_pos, k));
        sdiff_r[k] <= DIFF_W'(p_c[k]) - DIFF_W'(half(geom.sp_pos, k));
        psq_r[k]   <= pdiff_r[k] * pdiff_r[k];
        ssq_r[k]   <= sdiff_r[k] * sdiff_r[k];
        axp_r[k]   <= half(geom.sp_axis, k) * sdiff_r[k];
      end
      d2_pt_r <= $unsigned(psq_r[0]) + $unsigned(psq_r[1]) + $unsigned(psq_r[2]);
      d2_sp_r <= $unsigned(ssq_r[0]) + $unsigned(ssq_r[1]) + $unsigned(ssq_r[2]);
      dot_r   <= DOT_W'(axp_r[0]) + DOT_W'(axp_r[1]) + DOT_W'(axp_r[2]);
    end
  end

  assign out_vld   = vld_r[2];
  assign out_d2_pt = d2_pt_r;
  assign out_d2_sp = d2_sp_r;
  assign out_dot   = dot_r;

endmodule

/* rtl/plis_sqrt.sv */
`timescale 1ns / 1ps

module plis_sqrt
  import plis_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [D2_W-1:0]     in_val,
  output logic                out_vld,
  output logic [SQ_OUT_W-1:0] out_root
);

  logic [SQ_REM_W-1:0] r_r [SQ_OUT_W];
  logic [SQ_OUT_W-1:0] q_r [SQ_OUT_W];
  logic [D2_W-1:0]     n_r [SQ_OUT_W];
  logic [SQ_OUT_W-1:0] vld_r;

  for (genvar i = 0; i < SQ_OUT_W; i++) begin : g_step
    logic [SQ_REM_W-1:0] r_in;
    logic [SQ_OUT_W-1:0] q_in;
    logic [D2_W-1:0]     n_in;
    logic                v_in;
    logic [SQ_REM_W+1:0] t;
    logic [SQ_REM_W+1:0] trial;

    if (i == 0) begin : g_first
      assign r_in = '0;
      assign q_in = '0;
      assign n_in = in_val;
      assign v_in = in_vld;
    end else begin : g_next
      assign r_in = r_r[i-1];
      assign q_in = q_r[i-1];
      assign n_in = n_r[i-1];
      assign v_in = vld_r[i-1];
    end

    assign t     = {r_in, n_in[D2_W-1 -: 2]};
    assign trial = (SQ_REM_W + 2)'({q_in, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i] <= n_in << 2;
        if (t >= trial) begin
          r_r[i] <= SQ_REM_W'(t - trial);
          q_r[i] <= {q_in[SQ_OUT_W-2:0], 1'b1};
        end else begin
          r_r[i] <= SQ_REM_W'(t);
          q_r[i] <= {q_in[SQ_OUT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vld_r[SQ_OUT_W-1];
  assign out_root = q_r[SQ_OUT_W-1];

endmodule

/* rtl/plis_div.sv */
`timescale 1ns / 1ps

module plis_div
  import plis_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [DIV_NW-1:0] in_num,
  input  logic [DIV_DW-1:0] in_den,
  output logic              out_vld,
  output logic [DIV_QW-1:0] out_q
);

  logic [DIV_DW-1:0] r_r   [DIV_QW];
  logic [DIV_QW-1:0] nq_r  [DIV_QW];
  logic [DIV_DW-1:0] den_r [DIV_QW];
  logic [DIV_QW-1:0] vld_r;

  for (genvar i = 0; i < DIV_QW; i++) begin : g_step
    logic [DIV_DW-1:0] r_in;
    logic [DIV_QW-1:0] nq_in;
    logic [DIV_DW-1:0] den_in;
    logic              v_in;
    logic [DIV_DW:0]   t;

    if (i == 0) begin : g_first
      assign r_in   = DIV_DW'(in_num[DIV_NW-1:DIV_QW]);
      assign nq_in  = in_num[DIV_QW-1:0];
      assign den_in = in_den;
      assign v_in   = in_vld;
    end else begin : g_next
      assign r_in   = r_r[i-1];
      assign nq_in  = nq_r[i-1];
      assign den_in = den_r[i-1];
      assign v_in   = vld_r[i-1];
    end

    assign t = {r_in, nq_in[DIV_QW-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[i] <= den_in;
        if (t >= {1'b0, den_in}) begin
          r_r[i]  <= DIV_DW'(t - {1'b0, den_in});
          nq_r[i] <= {nq_in[DIV_QW-2:0], 1'b1};
        end else begin
          r_r[i]  <= DIV_DW'(t);
          nq_r[i] <= {nq_in[DIV_QW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld = vld_r[DIV_QW-1];
  assign out_q   = nq_r[DIV_QW-1];

endmodule

/* rtl/point_light_intensity_sum.sv */
`timescale 1ns / 1ps

// Throughput: one beat per cycle; the whole pipeline advances together and holds when
// a finished result is not taken.
// Reset: synchronous active-low rst_n clears all valid bits and returns the light
// registers to their reset values.

module point_light_intensity_sum
  import plis_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [15:0]           dir_level_r;
  logic [CFG_DATA_W-1:0] pt_pos_r;
  logic [15:0]           pt_peak_r;
  logic [15:0]           pt_fall_r;
  logic [CFG_DATA_W-1:0] sp_pos_r;
  logic [CFG_DATA_W-1:0] sp_axis_r;
  logic signed [15:0]    sp_cone_r;
  logic [15:0]           sp_peak_r;

  logic        en;
  light_geom_t geom;

  logic                    f_vld;
  logic [D2_W-1:0]         f_d2_pt;
  logic [D2_W-1:0]         f_d2_sp;
  logic signed [DOT_W-1:0] f_dot;

  logic                 pt4_vld_r;
  logic [PT_PROD_W-1:0] pt_prod_r;
  logic                 pt5_vld_r;
  logic [DIV_NW-1:0]    pt_num_r;
  logic [DIV_DW-1:0]    pt_den_r;
  logic                 pt_qv;
  logic [DIV_QW-1:0]    pt_q;
  logic [DIV_QW-1:0]    pt_dl_q_r [PT_DLY];
  logic [PT_DLY-1:0]    pt_dl_v_r;

  logic                    sq_vld;
  logic [SQ_OUT_W-1:0]     sq_root;
  logic signed [DOT_W-1:0] dot_dl_r [SQ_OUT_W];
  logic [D2_W-1:0]         d2_dl_r  [SQ_OUT_W];

  logic                vld21_r;
  logic                neg21_r;
  logic                zero21_r;
  logic [DOT_W-1:0]    absdot_r;
  logic [SQ_OUT_W-1:0] d_r;
  logic [D2_W-1:0]     d2_21_r;
  logic                ovf21;

  logic                cq_vld;
  logic [DIV_QW-1:0]   cq;
  logic [DIV_QW-1:0]   cs_neg_r;
  logic [DIV_QW-1:0]   cs_zero_r;
  logic [DIV_QW-1:0]   cs_ovf_r;
  logic [D2_W-1:0]     cs_d2_r [DIV_QW];

  logic                       big;
  logic [COS_MAG_W-1:0]       magc;
  logic signed [COS_MAG_W-1:0] cos_nxt;

  logic                    vld43_r;
  logic signed [COS_W-1:0] cos_r;
  logic [D2_W-1:0]         d2_43_r;
  logic [COS_W-1:0]        cos_abs;

  logic                 vld44_r;
  logic                 pass44_r;
  logic                 neg44_r;
  logic [SP_PROD_W-1:0] sp_prod_r;
  logic [DIV_DW-1:0]    sp_den_r;

  logic              sq_qv;
  logic [DIV_QW-1:0] sp_q;
  logic [DIV_QW-1:0] ss_pass_r;
  logic [DIV_QW-1:0] ss_neg_r;

  logic signed [TOT_W-1:0] dir_term;
  logic signed [TOT_W-1:0] pt_term;
  logic signed [TOT_W-1:0] spot_term;
  logic signed [TOT_W-1:0] total;

  logic      out_vld_r;
  out_beat_t out_beat_r;
  out_beat_t out_beat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_level_r <= '0;
      pt_pos_r    <= '0;
      pt_peak_r   <= '0;
      pt_fall_r   <= '0;
      sp_pos_r    <= '0;
      sp_axis_r   <= '0;
      sp_cone_r   <= CONE_COS_RESET;
      sp_peak_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DIR_LEVEL:  dir_level_r <= cfg_data[15:0];
        REG_PT_POS:     pt_pos_r    <= cfg_data;
        REG_PT_PEAK:    pt_peak_r   <= cfg_data[15:0];
        REG_PT_FALLOFF: pt_fall_r   <= cfg_data[15:0];
        REG_SP_POS:     sp_pos_r    <= cfg_data;
        REG_SP_AXIS:    sp_axis_r   <= cfg_data;
        REG_SP_CONE:    sp_cone_r   <= $signed(cfg_data[15:0]);
        REG_SP_PEAK:    sp_peak_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign en       = !out_vld_r || out_ready;
  assign in_ready = en;

  assign geom.pt_pos  = pt_pos_r;
  assign geom.sp_pos  = sp_pos_r;
  assign geom.sp_axis = sp_axis_r;

  plis_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_valid),
    .in_pt     (in_data),
    .geom      (geom),
    .out_vld   (f_vld),
    .out_d2_pt (f_d2_pt),
    .out_d2_sp (f_d2_sp),
    .out_dot   (f_dot)
  );

  // Point light path.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt4_vld_r <= 1'b0;
      pt5_vld_r <= 1'b0;
    end else if (en) begin
      pt4_vld_r <= f_vld;
      pt5_vld_r <= pt4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_prod_r <= pt_fall_r * f_d2_pt;
      pt_num_r  <= DIV_NW'(pt_peak_r) << (20 + 2 * COORD_FRAC_BITS);
      pt_den_r  <= PT_DEN_ONE + DIV_DW'(pt_prod_r);
    end
  end

  plis_div u_pt_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (pt5_vld_r),
    .in_num  (pt_num_r),
    .in_den  (pt_den_r),
    .out_vld (pt_qv),
    .out_q   (pt_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_dl_v_r <= '0;
    end else if (en) begin
      pt_dl_v_r <= {pt_dl_v_r[PT_DLY-2:0], pt_qv};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_dl_q_r[0] <= pt_q;
      for (int i = 1; i < PT_DLY; i++) begin
        pt_dl_q_r[i] <= pt_dl_q_r[i-1];
      end
    end
  end

  // Spot light path: distance, then cosine, then attenuated term.
  plis_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (f_vld),
    .in_val   (f_d2_sp),
    .out_vld  (sq_vld),
    .out_root (sq_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dot_dl_r[0] <= f_dot;
      d2_dl_r[0]  <= f_d2_sp;
      for (int i = 1; i < SQ_OUT_W; i++) begin
        dot_dl_r[i] <= dot_dl_r[i-1];
        d2_dl_r[i]  <= d2_dl_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld21_r <= 1'b0;
    end else if (en) begin
      vld21_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg21_r  <= dot_dl_r[SQ_OUT_W-1][DOT_W-1];
      absdot_r <= dot_dl_r[SQ_OUT_W-1][DOT_W-1] ? DOT_W'(-dot_dl_r[SQ_OUT_W-1])
                                                 : DOT_W'(dot_dl_r[SQ_OUT_W-1]);
      zero21_r <= (d2_dl_r[SQ_OUT_W-1] == '0);
      d2_21_r  <= d2_dl_r[SQ_OUT_W-1];
      d_r      <= sq_root;
    end
  end

  assign ovf21 = (absdot_r >> CLAMP_SHIFT) >= DOT_W'(d_r);

  plis_div u_cos_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vld21_r),
    .in_num  (DIV_NW'(absdot_r)),
    .in_den  (DIV_DW'(d_r)),
    .out_vld (cq_vld),
    .out_q   (cq)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      cs_neg_r   <= {cs_neg_r[DIV_QW-2:0], neg21_r};
      cs_zero_r  <= {cs_zero_r[DIV_QW-2:0], zero21_r};
      cs_ovf_r   <= {cs_ovf_r[DIV_QW-2:0], ovf21};
      cs_d2_r[0] <= d2_21_r;
      for (int i = 1; i < DIV_QW; i++) begin
        cs_d2_r[i] <= cs_d2_r[i-1];
      end
    end
  end

  always_comb begin
    big  = cs_ovf_r[DIV_QW-1] || (cq > COS_LIMIT_Q);
    magc = big ? COS_MAG_MAX : COS_MAG_W'(cq);
    if (cs_zero_r[DIV_QW-1]) begin
      cos_nxt = '0;
    end else if (cs_neg_r[DIV_QW-1]) begin
      cos_nxt = -$signed(magc);
    end else if (magc > COS_POS_MAX) begin
      cos_nxt = $signed(COS_POS_MAX);
    end else begin
      cos_nxt = $signed(magc);
    end
  end

  assign cos_abs = cos_r[COS_W-1] ? COS_W'(-cos_r) : COS_W'(cos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld43_r <= 1'b0;
      vld44_r <= 1'b0;
    end else if (en) begin
      vld43_r <= cq_vld;
      vld44_r <= vld43_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r     <= COS_W'(cos_nxt);
      d2_43_r   <= cs_d2_r[DIV_QW-1];
      pass44_r  <= (cos_r >= sp_cone_r);
      neg44_r   <= cos_r[COS_W-1];
      sp_prod_r <= sp_peak_r * cos_abs;
      sp_den_r  <= DIV_DW'((D2_W + 1)'(d2_43_r) + SP_DEN_ONE) << 10;
    end
  end

  plis_div u_sp_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vld44_r),
    .in_num  (DIV_NW'(sp_prod_r) << (2 * COORD_FRAC_BITS)),
    .in_den  (sp_den_r),
    .out_vld (sq_qv),
    .out_q   (sp_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ss_pass_r <= {ss_pass_r[DIV_QW-2:0], pass44_r};
      ss_neg_r  <= {ss_neg_r[DIV_QW-2:0], neg44_r};
    end
  end

  // Final sum and saturation.
  always_comb begin
    dir_term = $signed(TOT_W'({dir_level_r, 4'b0000}));
    pt_term  = $signed(TOT_W'(pt_dl_q_r[PT_DLY-1]));
    if (!ss_pass_r[DIV_QW-1]) begin
      spot_term = '0;
    end else if (ss_neg_r[DIV_QW-1]) begin
      spot_term = -$signed(TOT_W'(sp_q));
    end else begin
      spot_term = $signed(TOT_W'(sp_q));
    end
    total = dir_term + pt_term + spot_term;
    if (total > OUT_MAX) begin
      out_beat_nxt.total_light = OUT_W'(OUT_MAX);
      out_beat_nxt.saturated   = 1'b1;
    end else if (total < OUT_MIN) begin
      out_beat_nxt.total_light = OUT_W'(OUT_MIN);
      out_beat_nxt.saturated   = 1'b1;
    end else begin
      out_beat_nxt.total_light = OUT_W'(total);
      out_beat_nxt.saturated   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= sq_qv && pt_dl_v_r[PT_DLY-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_beat_r;

endmodule
